### sv/srb_pkg.sv
package srb_pkg;

    localparam int DEPTH      = 64;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int MAX_PACKET = 2048;
    localparam int SEQ_W      = 32;
    localparam int LEN_W      = 12;
    localparam int WIN_W      = 7;
    localparam int CFG_W      = 32;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(64);

    // opcodes
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    // register indexes
    localparam logic REG_START_SEQUENCE  = 1'b0;
    localparam logic REG_PREFETCH_WINDOW = 1'b1;

    // result status codes
    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_DROPPED   = 3'd1;
    localparam logic [2:0] ST_REQUEST   = 3'd2;
    localparam logic [2:0] ST_DELIVERED = 3'd3;
    localparam logic [2:0] ST_NOT_READY = 3'd4;

    typedef struct packed {
        logic              opcode;
        logic [SEQ_W-1:0]  arrival_sequence;
        logic [31:0]       packet_handle;
        logic [LEN_W-1:0]  packet_length;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [SEQ_W-1:0]  delivered_sequence;
        logic [31:0]       delivered_handle;
        logic [LEN_W-1:0]  delivered_length;
        logic [SEQ_W-1:0]  request_first;
        logic [SEQ_W:0]    request_end;
    } out_item_t;

    // classified item passed from front to back
    typedef struct packed {
        logic              opcode;
        logic              bad_length;
        logic [SEQ_W-1:0]  arrival_sequence;
        logic [31:0]       packet_handle;
        logic [LEN_W-1:0]  packet_length;
    } q_item_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  sequence_num;
        logic [31:0]       handle;
        logic [LEN_W-1:0]  length;
    } slot_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } back_state_t;

endpackage

### sv/srb_front.sv
module srb_front
    import srb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output logic     q_valid,
    output q_item_t  q_item,
    input  logic     q_pop
);

    q_item_t    ents_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    q_item_t    cls;

    // length check done up front so the back only sees a flag
    always_comb
    begin
        cls.opcode           = in_data.opcode;
        cls.bad_length       = (in_data.packet_length == '0) ||
                               (in_data.packet_length > LEN_W'(MAX_PACKET));
        cls.arrival_sequence = in_data.arrival_sequence;
        cls.packet_handle    = in_data.packet_handle;
        cls.packet_length    = in_data.packet_length;
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = ents_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ents_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, q_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### sv/srb_back.sv
module srb_back
    import srb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  q_item_t          q_item,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    back_state_t       state_reg;
    back_state_t       state_next;
    q_item_t           cur_reg;
    logic [IDX_W-1:0]  idx_reg;
    slot_t             mem_reg [DEPTH];
    slot_t             rd_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic [SEQ_W-1:0]  expected_reg;
    logic [SEQ_W-1:0]  highest_reg;
    logic [WIN_W-1:0]  window_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [IDX_W-1:0]  rd_idx;
    logic              fire;
    logic [SEQ_W-1:0]  hr_fix;
    logic [SEQ_W:0]    win_end;
    logic              in_win;
    logic              occupied;
    logic              store;
    logic              req;
    logic              hit;
    out_item_t         res;

    assign q_pop  = (state_reg == S_IDLE) && q_valid;
    assign rd_idx = (q_item.opcode == OP_TAKE) ? expected_reg[IDX_W-1:0]
                                               : q_item.arrival_sequence[IDX_W-1:0];
    assign fire   = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        hr_fix   = (highest_reg < expected_reg) ? expected_reg : highest_reg;
        win_end  = {1'b0, expected_reg} + (SEQ_W+1)'(window_reg);
        in_win   = (cur_reg.arrival_sequence >= expected_reg) &&
                   ({1'b0, cur_reg.arrival_sequence} < win_end);
        // a slot holding a sequence below expected is stale and may be reused
        occupied = valid_reg[idx_reg] && (rd_reg.sequence_num >= expected_reg);
        store    = (cur_reg.opcode == OP_ARRIVE) && !cur_reg.bad_length &&
                   in_win && !occupied;
        req      = store && (cur_reg.arrival_sequence > hr_fix);
        hit      = valid_reg[idx_reg] && (rd_reg.sequence_num == expected_reg);

        res = '0;
        if (cur_reg.opcode == OP_ARRIVE)
        begin
            if (req)
            begin
                res.status        = ST_REQUEST;
                res.request_first = expected_reg;
                res.request_end   = {1'b0, expected_reg} + (SEQ_W+1)'(DEPTH);
            end
            else if (store)
            begin
                res.status = ST_STORED;
            end
            else
            begin
                res.status = ST_DROPPED;
            end
        end
        else if (hit)
        begin
            res.status             = ST_DELIVERED;
            res.delivered_sequence = rd_reg.sequence_num;
            res.delivered_handle   = rd_reg.handle;
            res.delivered_length   = rd_reg.length;
        end
        else
        begin
            res.status = ST_NOT_READY;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // slot storage: read when an item is popped, written when a stored arrival completes
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
            idx_reg <= rd_idx;
            rd_reg  <= mem_reg[rd_idx];
        end
        if (fire && store)
        begin
            mem_reg[idx_reg] <= '{sequence_num: cur_reg.arrival_sequence,
                                  handle:       cur_reg.packet_handle,
                                  length:       cur_reg.packet_length};
        end
        if (fire)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            expected_reg  <= '0;
            highest_reg   <= '0;
            window_reg    <= WINDOW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_START_SEQUENCE:
                    begin
                        expected_reg <= cfg_data[SEQ_W-1:0];
                        highest_reg  <= cfg_data[SEQ_W-1:0];
                    end
                    REG_PREFETCH_WINDOW:
                    begin
                        window_reg <= cfg_data[WIN_W-1:0];
                    end
                    default:
                    begin
                        window_reg <= window_reg;
                    end
                endcase
            end
            else if (fire)
            begin
                if (cur_reg.opcode == OP_ARRIVE)
                begin
                    highest_reg <= req ? cur_reg.arrival_sequence : hr_fix;
                    if (store)
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                    end
                end
                else if (hit)
                begin
                    valid_reg[idx_reg] <= 1'b0;
                    expected_reg       <= expected_reg + SEQ_W'(1);
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### sv/sequenced_reorder_buffer_top.sv
// Sequenced reorder buffer: packets carrying sequence numbers arrive in any
// order on the input channel (opcode arrive) and are parked in a ring of 64
// slots indexed by sequence modulo 64; a take (opcode take) returns the
// packet at the expected sequence, or a not-ready status if it is missing.
// Every input item yields exactly one result item on the output channel.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. The config port writes start_sequence (index 0, also reloads the
// expected and highest-requested counters) and prefetch_window (index 1);
// write only while the block is idle.
// Each item passes from the input queue to a pop with slot read, then to the
// execute step that registers the result. The back end pops a new item only
// after the current one has executed, and execute holds while the output stalls.
// A 2-entry queue decouples input from the back end, so input keeps being
// accepted while a result waits on a stalled output; when the queue fills,
// in_stall rises. Reset clears all slots, sets the expected sequence to 0
// and the window to 64; no clearing pass is needed.
module sequenced_reorder_buffer_top
    import srb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic    q_valid;
    logic    q_pop;
    q_item_t q_item;

    srb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    srb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
